// ===== design/assert_macros.svh =====
// Assertion macros shared by the voice RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SVR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define SVR_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== design/svr_pkg.sv =====
// Types and constants of the sawtooth voice with release tail.
package svr_pkg;

	localparam int CMD_W     = 2;
	localparam int NOTE_W    = 7;
	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 15;
	// level and gain are both Q1.15, so the product carries 30 fraction bits
	localparam int ROUND_SHIFT = 2 * GAIN_FRAC;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_DECAY  = 16'd32440;
	localparam logic [GAIN_W-1:0]  GAIN_FLOOR  = 16'd1638;
	localparam int NOTE_COUNT = 128;
	localparam int A4_HZ      = 440;

	// 2^(k/12) in Q24
	localparam logic [31:0] SEMITONE_Q24 [12] = '{
		32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
		32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
		32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
	};

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_START   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_STOP    = 2'd3
	} svr_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} svr_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NOTE_W-1:0] note_number;
	} svr_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       voice_active;
	} svr_out_t;

	typedef struct packed {
		logic load;
		logic step;
	} svr_mul_ctrl_t;

	typedef struct packed {
		logic start;
		logic shift;
		logic clear_phase;
		logic load_step;
		logic clear_step;
	} svr_acc_ctrl_t;

endpackage

// ===== design/svr_mul_serial.sv =====
// Serial-parallel multiplier: signed multiplicand times unsigned multiplier, one bit a cycle while step is set.
module svr_mul_serial #(
	parameter int AW = 32,
	parameter int BW = 16
) (
	input  logic                      clk,
	input  svr_pkg::svr_mul_ctrl_t    ctrl,
	input  logic signed [AW-1:0]      a,
	input  logic [BW-1:0]             b,
	output logic signed [AW+BW-1:0]   prod
);
	import svr_pkg::*;

	logic signed [AW-1:0] a_q;
	logic [BW-1:0]        b_q;
	logic signed [AW-1:0] hi_q;
	logic [BW-1:0]        lo_q;
	logic signed [AW:0]   sum;

	// add the multiplicand when the current multiplier bit is set
	always_comb begin
		sum = {hi_q[AW-1], hi_q} + (b_q[0] ? {a_q[AW-1], a_q} : {(AW+1){1'b0}});
	end

	// load operands, then shift the partial product right one bit per step
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctrl.step) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign prod = {hi_q, lo_q};

endmodule

// ===== design/svr_phase_acc.sv =====
// Bit-serial phase accumulator holding the phase and its per-tick step.
module svr_phase_acc #(
	parameter int PHASE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  svr_pkg::svr_acc_ctrl_t   ctrl,
	input  logic [PHASE_BITS-1:0]    step_in,
	output logic [PHASE_BITS-1:0]    phase
);
	import svr_pkg::*;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic                  carry_q;
	logic                  sum_bit;
	logic                  carry_d;

	// full adder on the low bits of both rotating words
	always_comb begin
		sum_bit = phase_q[0] ^ step_q[0] ^ carry_q;
		carry_d = (phase_q[0] & step_q[0]) | (carry_q & (phase_q[0] ^ step_q[0]));
	end

	// rotate both words one bit per step; a full turn of steps leaves the sum in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			carry_q <= 1'b0;
		end else begin
			if (ctrl.clear_phase) begin
				phase_q <= '0;
			end else if (ctrl.shift) begin
				phase_q <= {sum_bit, phase_q[PHASE_BITS-1:1]};
			end

			if (ctrl.load_step) begin
				step_q <= step_in;
			end else if (ctrl.clear_step) begin
				step_q <= '0;
			end else if (ctrl.shift) begin
				step_q <= {step_q[0], step_q[PHASE_BITS-1:1]};
			end

			if (ctrl.start) begin
				carry_q <= 1'b0;
			end else if (ctrl.shift) begin
				carry_q <= carry_d;
			end
		end
	end

	assign phase = phase_q;

endmodule

// ===== design/sawtooth_voice_with_release_core.sv =====
// Top level of the sawtooth voice with exponential release tail.
`include "assert_macros.svh"

// A sample tick (command 0) returns one result; start note, release and hard stop
// return none and complete in the cycle they are accepted. A tick runs through a
// bit-serial datapath: the sample multiply takes two passes (times level, then
// times release gain) on one serial-parallel multiplier, while the phase add
// runs bit-serially over PHASE_BITS bits and a second serial multiplier decays the
// gain. A tick's result enters the output register as the sequencer leaves its
// done state, and the next item is taken only back in idle, so a new tick is not
// accepted before the previous one has finished. While the output register still
// holds an earlier result that has not been transferred out, the tick waits in its
// last step and the input stays stalled. Level writes are taken at any cycle and
// apply from the next tick on.
module sawtooth_voice_with_release_core #(
	parameter int SAMPLE_RATE = 48000,
	parameter int PHASE_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  svr_pkg::svr_in_t                   cmd_data,
	output logic                               smp_valid,
	input  logic                               smp_ready,
	output svr_pkg::svr_out_t                  smp_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [svr_pkg::LEVEL_W-1:0]        cfg_data
);
	import svr_pkg::*;

	localparam int MUL_AW    = SAMPLE_W + LEVEL_W;
	localparam int MUL_PW    = MUL_AW + GAIN_W;
	localparam int GMUL_PW   = 2 * GAIN_W;
	localparam int RND_W     = MUL_PW - ROUND_SHIFT;
	localparam int PASS_LAST = 2 * GAIN_W;
	localparam int RUN_LAST  = (PHASE_BITS - 1 > PASS_LAST) ? PHASE_BITS - 1 : PASS_LAST;
	localparam int CNT_W     = $clog2(RUN_LAST + 1);
	localparam int STEP_GUARD = 14;
	localparam logic [127:0] STEP_DEN = 128'(SAMPLE_RATE) << STEP_GUARD;
	localparam logic [CNT_W-1:0] RUN_LAST_C = CNT_W'(RUN_LAST);

	// phase step for a note, rounded half up, wrapped to the phase width
	function automatic logic [PHASE_BITS-1:0] calc_step(input int note);
		int           m;
		int           q;
		int           k;
		logic [127:0] num;
		m   = note + 3;
		q   = m / 12;
		k   = m % 12;
		num = 128'(A4_HZ) * 128'(SEMITONE_Q24[k]);
		num = num << (q - 30 + PHASE_BITS + STEP_GUARD);
		return PHASE_BITS'((num + (STEP_DEN >> 1)) / STEP_DEN);
	endfunction

	// note to phase step lookup, built at elaboration
	logic [PHASE_BITS-1:0] step_rom [NOTE_COUNT];
	for (genvar gi = 0; gi < NOTE_COUNT; gi++) begin : g_rom
		localparam logic [PHASE_BITS-1:0] STEP_VAL = calc_step(gi);
		assign step_rom[gi] = STEP_VAL;
	end

	svr_state_t            state_q;
	svr_state_t            state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [GAIN_W-1:0]     rg_q;
	logic                  active_q;
	logic                  smp_valid_q;
	svr_out_t              smp_q;

	svr_cmd_t              cmd;
	logic                  cmd_fire;
	logic                  tick_fire;
	logic                  done_fire;
	logic                  out_free;

	svr_mul_ctrl_t               mul_ctrl;
	logic signed [MUL_AW-1:0]    mul_a;
	logic [LEVEL_W-1:0]          mul_b;
	logic signed [MUL_PW-1:0]    mul_prod;
	svr_mul_ctrl_t               gmul_ctrl;
	logic signed [GMUL_PW-1:0]   gmul_prod;
	svr_acc_ctrl_t               acc_ctrl;
	logic [PHASE_BITS-1:0]       phase;

	logic [PHASE_BITS+SAMPLE_W-1:0] phase_ext;
	logic signed [SAMPLE_W-1:0]     saw;
	logic [GAIN_W-1:0]              g_eff;
	logic signed [MUL_PW-1:0]       rnd;
	logic signed [RND_W-1:0]        rshift;
	logic [RND_W-SAMPLE_W:0]        top_bits;
	logic signed [SAMPLE_W-1:0]     sat;
	logic [GMUL_PW-1:0]             gsum;
	logic [GAIN_W-1:0]              g_next;
	logic                           releasing;
	logic                           rel_end;
	svr_out_t                       smp_d;
	logic                           in_run;
	logic                           run_mid;
	logic                           gain_bad;

	assign cmd       = svr_cmd_t'(cmd_data.command);
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid & cmd_ready;
	assign tick_fire = cmd_fire && (cmd == CMD_TICK);
	assign out_free  = !smp_valid_q || smp_ready;
	assign done_fire = (state_q == ST_DONE) && out_free;
	assign cfg_ready = 1'b1;

	// sawtooth: the phase bits just below the top bit, read as signed
	assign phase_ext = {phase, {SAMPLE_W{1'b0}}};
	assign saw       = phase_ext[PHASE_BITS+SAMPLE_W-2 -: SAMPLE_W];
	assign g_eff     = (rg_q != '0) ? rg_q : GAIN_ONE;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_fire) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cnt_q == RUN_LAST_C) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier passes and serial phase add
	always_comb begin
		mul_ctrl  = '0;
		gmul_ctrl = '0;
		acc_ctrl  = '0;
		mul_a     = MUL_AW'(saw);
		mul_b     = level_q;
		unique case (state_q)
			ST_IDLE: begin
				mul_ctrl.load   = tick_fire;
				gmul_ctrl.load  = tick_fire;
				acc_ctrl.start  = tick_fire;
				acc_ctrl.clear_phase = cmd_fire && (cmd == CMD_START || cmd == CMD_STOP);
				acc_ctrl.load_step   = cmd_fire && (cmd == CMD_START);
			end
			ST_RUN: begin
				mul_a = mul_prod[MUL_AW-1:0];
				mul_b = g_eff;
				mul_ctrl.load  = (cnt_q == CNT_W'(GAIN_W));
				mul_ctrl.step  = (cnt_q < CNT_W'(GAIN_W)) ||
					((cnt_q > CNT_W'(GAIN_W)) && (cnt_q <= CNT_W'(PASS_LAST)));
				gmul_ctrl.step = (cnt_q < CNT_W'(GAIN_W));
				acc_ctrl.shift = (cnt_q <= CNT_W'(PHASE_BITS - 1));
			end
			ST_DONE: begin
				acc_ctrl.clear_step = done_fire && rel_end;
			end
			default: begin
				mul_ctrl = '0;
			end
		endcase
	end

	// round, saturate and gate the sample; decay the release gain
	always_comb begin
		rnd      = mul_prod + (MUL_PW'(1) <<< (ROUND_SHIFT - 1));
		rshift   = rnd[MUL_PW-1:ROUND_SHIFT];
		top_bits = rshift[RND_W-1:SAMPLE_W-1];
		if ((&top_bits) || !(|top_bits)) begin
			sat = rshift[SAMPLE_W-1:0];
		end else if (rshift[RND_W-1]) begin
			sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		gsum      = gmul_prod + GMUL_PW'(1 << (GAIN_FRAC - 1));
		g_next    = gsum[GAIN_FRAC +: GAIN_W];
		releasing = active_q && (rg_q != '0);
		rel_end   = releasing && (g_next <= GAIN_FLOOR);
		smp_d.sample       = active_q ? sat : '0;
		smp_d.voice_active = active_q && !rel_end;
	end

	svr_mul_serial #(
		.AW(MUL_AW),
		.BW(LEVEL_W)
	) u_mul (
		.clk  (clk),
		.ctrl (mul_ctrl),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	svr_mul_serial #(
		.AW(GAIN_W),
		.BW(GAIN_W)
	) u_gain_mul (
		.clk  (clk),
		.ctrl (gmul_ctrl),
		.a    (GAIN_DECAY),
		.b    (rg_q),
		.prod (gmul_prod)
	);

	svr_phase_acc #(
		.PHASE_BITS(PHASE_BITS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.step_in (step_rom[cmd_data.note_number]),
		.phase   (phase)
	);

	// control state: sequencer, level, release gain, voice on flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			level_q     <= LEVEL_RESET;
			rg_q        <= '0;
			active_q    <= 1'b0;
			smp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (tick_fire) begin
				cnt_q <= '0;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (cfg_valid && cfg_ready) begin
				level_q <= cfg_data;
			end

			if (cmd_fire) begin
				case (cmd)
					CMD_START: begin
						rg_q     <= '0;
						active_q <= 1'b1;
					end
					CMD_RELEASE: begin
						if (active_q && rg_q == '0) rg_q <= GAIN_ONE;
					end
					CMD_STOP: begin
						rg_q     <= '0;
						active_q <= 1'b0;
					end
					default: begin
						rg_q <= rg_q;
					end
				endcase
			end else if (done_fire && releasing) begin
				if (rel_end) begin
					rg_q     <= '0;
					active_q <= 1'b0;
				end else begin
					rg_q <= g_next;
				end
			end

			if (done_fire) begin
				smp_valid_q <= 1'b1;
			end else if (smp_ready) begin
				smp_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until it is transferred out
	always_ff @(posedge clk) begin
		if (done_fire) begin
			smp_q <= smp_d;
		end
	end

	assign smp_valid = smp_valid_q;
	assign smp_data  = smp_q;

	// terms for the checks below
	assign in_run   = (state_q == ST_RUN);
	assign run_mid  = in_run && (cnt_q != RUN_LAST_C);
	assign gain_bad = (rg_q > GAIN_ONE) || ((rg_q != '0) && (rg_q <= GAIN_FLOOR));

	`SVR_ASSERT(a_release_active, (rg_q != '0) |-> active_q, "release gain on a silent voice")
	`SVR_NEVER(a_gain_range, gain_bad, "release gain out of range")
	`SVR_ASSERT(a_run_count, run_mid |=> in_run && (cnt_q == $past(cnt_q) + 1'b1), "count skip")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the sawtooth voice with exponential release tail.
`timescale 1ns / 100ps

module testbench;
	import svr_pkg::*;

	localparam int ITEM_TOTAL      = 1450;
	localparam int LEVEL_PHASES    = 5;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SQUEEZE_AT      = 900;
	localparam int SQUEEZE_CYCLES  = 300;
	localparam int CALM_FIRST      = 400;
	localparam int CALM_LAST       = 600;
	localparam int QUARTER_SEARCH  = 1024;

	// voice arithmetic
	localparam int PHASE_W              = 32;
	localparam longint unsigned RATE_HZ = 48000;
	localparam int A4_FREQ              = 440;
	localparam int TAIL_ONE             = 32768;
	localparam int unsigned TAIL_DECAY  = 32440;
	localparam int TAIL_FLOOR           = 1638;
	// 2^(k/12) in Q24
	localparam logic [31:0] SEMI_RATIO [12] = '{
		32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
		32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
		32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
	};

	typedef struct packed {
		svr_cmd_t           command;
		logic [6:0]         note;
		logic               typed;
		logic signed [15:0] exp_sample;
		logic               exp_on;
	} row_t;

	// directed opening: fixed results where they are obvious, predictor elsewhere
	localparam int ROW_COUNT = 24;
	localparam row_t DIRECTED_ROWS [ROW_COUNT] = '{
		'{CMD_TICK,    7'd127, 1'b1, 16'sd0, 1'b0},  // silent after reset
		'{CMD_RELEASE, 7'd0,   1'b0, 16'sd0, 1'b0},  // release while silent
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b0},
		'{CMD_START,   7'd0,   1'b0, 16'sd0, 1'b0},  // lowest note
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b1},  // phase starts at zero
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_TICK,    7'd127, 1'b0, 16'sd0, 1'b0},
		'{CMD_START,   7'd127, 1'b0, 16'sd0, 1'b0},  // highest note
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b1},
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_RELEASE, 7'd127, 1'b0, 16'sd0, 1'b0},
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_RELEASE, 7'd0,   1'b0, 16'sd0, 1'b0},  // already releasing
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_STOP,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b0},  // stopped: silent
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b0},
		'{CMD_START,   7'd69,  1'b0, 16'sd0, 1'b0},
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b1},
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0},
		'{CMD_START,   7'd64,  1'b0, 16'sd0, 1'b0},  // restart mid-note
		'{CMD_TICK,    7'd0,   1'b1, 16'sd0, 1'b1},
		'{CMD_TICK,    7'd0,   1'b0, 16'sd0, 1'b0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	svr_in_t cmd_data = '0;
	logic smp_valid;
	logic smp_ready = 1'b0;
	svr_out_t smp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEVEL_W-1:0] cfg_data = '0;

	// predicted voice state
	logic [31:0] osc_phase = '0;
	logic [31:0] osc_step = '0;
	logic [15:0] tail_gain = '0;
	logic [15:0] level_reg = 16'd32768;
	logic voice_on = 1'b0;

	svr_out_t expected_samples [$];
	svr_out_t head_result;
	int unsigned items_sent = 0;
	int error_count = 0;
	bit calm = 1'b0;
	bit squeeze_req = 1'b0;

	sawtooth_voice_with_release_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp_data  (smp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// phase step per sample for a MIDI note, rounded half up
	function automatic logic [31:0] note_increment(input logic [6:0] note);
		int unsigned m, octave, semi;
		longint unsigned num;
		m = 32'(note) + 3;
		octave = m / 12;
		semi = m % 12;
		num = 64'(A4_FREQ) * 64'(SEMI_RATIO[semi]);
		num = num << (octave + PHASE_W - 30);
		return 32'((num + RATE_HZ / 2) / RATE_HZ);
	endfunction

	// advance the predicted voice by one command
	task automatic voice_advance(input svr_in_t item, output bit yields,
			output svr_out_t outcome);
		logic signed [15:0] saw;
		longint g, product, scaled;
		int unsigned decayed;
		yields = 1'b0;
		outcome = '0;
		case (svr_cmd_t'(item.command))
			CMD_START: begin
				osc_step = note_increment(item.note_number);
				osc_phase = '0;
				tail_gain = '0;
				voice_on = 1'b1;
			end
			CMD_RELEASE: begin
				if (voice_on && tail_gain == 0)
					tail_gain = 16'(TAIL_ONE);
			end
			CMD_STOP: begin
				voice_on = 1'b0;
				osc_phase = '0;
				tail_gain = '0;
			end
			default: begin
				// ramp from the bits under the top phase bit, scaled by level and gain
				saw = osc_phase[30:15];
				g = (tail_gain != 0) ? longint'(tail_gain) : longint'(TAIL_ONE);
				product = longint'(saw) * longint'(level_reg) * g;
				scaled = (product + (longint'(1) <<< 29)) >>> 30;
				if (scaled > 32767)
					scaled = 32767;
				else if (scaled < -32768)
					scaled = -32768;
				outcome.sample = voice_on ? 16'(scaled) : 16'sd0;
				osc_phase = osc_phase + osc_step;
				// decay the tail and fall silent at the floor
				if (voice_on && tail_gain != 0) begin
					decayed = (32'(tail_gain) * TAIL_DECAY + 32'd16384) >> 15;
					tail_gain = 16'(decayed);
					if (tail_gain <= TAIL_FLOOR) begin
						voice_on = 1'b0;
						osc_step = '0;
						tail_gain = '0;
					end
				end
				outcome.voice_active = voice_on;
				yields = 1'b1;
			end
		endcase
	endtask

	// offer one command, record what it should produce
	task automatic offer_command(input svr_cmd_t command, input logic [6:0] note,
			input bit pinned = 1'b0, input svr_out_t pinned_result = '0);
		svr_in_t item;
		svr_out_t outcome;
		bit yields;
		item.command = command;
		item.note_number = note;
		if (!calm && $urandom_range(0, 99) < 18) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= item;
		do @(posedge clk); while (!cmd_ready);
		voice_advance(item, yields, outcome);
		if (yields)
			expected_samples.push_back(pinned ? pinned_result : outcome);
		items_sent++;
		calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
		if (items_sent == SQUEEZE_AT)
			squeeze_req = 1'b1;
	endtask

	task automatic offer_ticks(input int count);
		repeat (count) offer_command(CMD_TICK, 7'($urandom_range(0, 127)));
	endtask

	// drop valid and wait until every sample is back and the block is idle
	task automatic settle_voice();
		cmd_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		level_reg = value;
	endtask

	task automatic report_miss(input string what, input longint want, input longint got);
		if (error_count < 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		error_count++;
	endtask

	// main sequence
	initial begin
		svr_out_t pinned;
		row_t row;
		int roll, tail, best_note, best_ticks;
		logic [31:0] probe_step, probe_phase;
		logic [15:0] phase_levels [LEVEL_PHASES];
		int unsigned phase_goal;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROW_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			pinned.sample = row.exp_sample;
			pinned.voice_active = row.exp_on;
			offer_command(row.command, row.note, row.typed, pinned);
		end

		// find a note whose ramp lands on the quarter turn soonest, then play it there
		best_ticks = -1;
		best_note = 0;
		for (int note = 0; note < 128; note++) begin
			probe_step = note_increment(7'(note));
			probe_phase = '0;
			for (int n = 0; n < QUARTER_SEARCH; n++) begin
				if (probe_phase[30:15] == 16'h8000 && (best_ticks < 0 || n < best_ticks)) begin
					best_note = note;
					best_ticks = n;
				end
				probe_phase = probe_phase + probe_step;
			end
		end
		if (best_ticks >= 0) begin
			offer_command(CMD_START, 7'(best_note));
			offer_ticks(best_ticks + 1);
		end
		settle_voice();

		phase_levels = '{16'd0, 16'hFFFF, 16'($urandom), 16'd32768,
			16'($urandom_range(32769, 65534))};
		for (int p = 0; p < LEVEL_PHASES; p++) begin
			write_level(phase_levels[p]);
			phase_goal = ITEM_TOTAL * (p + 1) / LEVEL_PHASES;
			do begin
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					// stray command with arbitrary content
					offer_command(svr_cmd_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
				end else begin
					// a note: start, hold, then release, stop or cut by the next start
					offer_command(CMD_START, 7'($urandom_range(0, 127)));
					offer_ticks($urandom_range(1, 40));
					roll = $urandom_range(0, 99);
					if (roll < 60) begin
						offer_command(CMD_RELEASE, 7'($urandom_range(0, 127)));
						if ($urandom_range(0, 1) == 1) begin
							offer_ticks($urandom_range(1, 10));
							offer_command(CMD_RELEASE, 7'($urandom_range(0, 127)));
						end
						tail = ($urandom_range(0, 99) < 35) ? $urandom_range(300, 330)
							: $urandom_range(1, 60);
						offer_ticks(tail);
					end else if (roll < 80) begin
						offer_command(CMD_STOP, 7'($urandom_range(0, 127)));
						offer_ticks($urandom_range(0, 5));
					end
				end
			end while (items_sent < phase_goal);
			settle_voice();
		end

		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// sample receiver: random stalls, one long hold-off to back the block up
	initial begin
		bit squeeze_done;
		squeeze_done = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				smp_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES - 1) @(posedge clk);
				squeeze_done = 1'b1;
			end else begin
				smp_ready <= calm || ($urandom_range(0, 99) >= 18);
			end
		end
	end

	// compare each sample transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && smp_valid && smp_ready) begin
			if (expected_samples.size() == 0) begin
				report_miss("sample with nothing pending", 0, smp_data.sample);
			end else begin
				head_result = expected_samples.pop_front();
				if (smp_data.sample !== head_result.sample)
					report_miss("sample", head_result.sample, smp_data.sample);
				if (smp_data.voice_active !== head_result.voice_active)
					report_miss("voice_active", head_result.voice_active,
						smp_data.voice_active);
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (smp_valid && smp_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/svr_pkg.sv
design/svr_mul_serial.sv
design/svr_phase_acc.sv
design/sawtooth_voice_with_release_core.sv
test/testbench.sv
